// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dkbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dkbc_pkg
// Types and fixed codes of the digit keystream byte cipher.
// ----------------------------------------------------------------------------
package dkbc_pkg;

  // Digit count, position and store index arithmetic
  localparam int CNT_W = 17;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CNT_W:0]   wide_t;

  // Commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_PROCESS = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_3  = 3'd6;

  localparam int OFFSET_REGS = 4;
  localparam int OFS_IW      = 2;
  typedef logic [15:0] offset_t;

  localparam count_t       COUNT_RESET  = 17'h10000;
  localparam logic [2:0]   LAYERS_RESET = 3'd1;

  // Digit phase within one layer
  localparam logic [1:0] PH_HUND = 2'd0;
  localparam logic [1:0] PH_TENS = 2'd1;
  localparam logic [1:0] PH_ONES = 2'd2;

  localparam logic [10:0] W_HUND = 11'd100;
  localparam logic [10:0] W_TENS = 11'd10;

  // Remainder unit: one dividend bit per cycle
  localparam int MOD_STEPS = CNT_W + 1;
  localparam int MOD_CW    = 5;

endpackage

// ----- src/digit_keystream_byte_cipher.sv -----
// ----------------------------------------------------------------------------
// digit_keystream_byte_cipher
// Byte cipher keyed by a stored string of decimal digits.
//
// Input beats carry a command: load writes one digit into the store, start
// sets the stream position to the first layer offset, process transforms one
// byte. Load and start give no result; a process beat gives one out_byte
// beat. Each layer reads three digits from the single-port digit store, one
// read a cycle, and the next byte is taken only once the result of the last
// one has gone to the output register; a position advance that does not fold
// back with one subtraction goes through the bit-serial remainder unit. A
// bypassed byte skips the digit reads. A configuration write reduces all
// layer offsets and the position modulo the digit count, one after another
// in the remainder unit, during which no input beat is taken. Reset restores
// the register defaults and a zero position; the digit store is not cleared.
// A stalled receiver holds the result register; one more beat is still
// accepted and waits behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module digit_keystream_byte_cipher
  import dkbc_pkg::*;
#(
  parameter int DIGIT_DEPTH = 65536,
  parameter int MAX_LAYERS  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [15:0]           in_digit_address,
  input  logic [3:0]            in_digit_value,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_bypass,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam int LIM = (MAX_LAYERS < OFFSET_REGS) ? MAX_LAYERS : OFFSET_REGS;
  localparam int LW  = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int RW  = $clog2(LIM + 1);
  // Largest usable digit count: store depth, or what the count register holds
  localparam int CAP = (DIGIT_DEPTH < (1 << CNT_W)) ? DIGIT_DEPTH : (1 << CNT_W) - 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take beats
  localparam logic [2:0] ST_RED   = 3'd1;  // reduce offsets and position
  localparam logic [2:0] ST_LAYER = 3'd2;  // issue digit reads
  localparam logic [2:0] ST_DRAIN = 3'd3;  // last digit returns
  localparam logic [2:0] ST_ADV   = 3'd4;  // advance position
  localparam logic [2:0] ST_MODP  = 3'd5;  // slow position fold
  localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to output register

  logic [2:0]     state_r, state_nxt;
  logic           dirty_r, dirty_nxt;
  logic           direction_r, direction_nxt;
  logic [2:0]     layers_r, layers_nxt;
  count_t         count_r, count_nxt;
  offset_t        offset_r [OFFSET_REGS];
  offset_t        offset_nxt [OFFSET_REGS];
  count_t         off_red_r [LIM];
  count_t         off_red_nxt [LIM];
  count_t         pos_r, pos_nxt;
  logic [RW-1:0]  ridx_r, ridx_nxt;
  logic [LW-1:0]  j_r, j_nxt;
  logic [1:0]     ph_r, ph_nxt;
  count_t         addr_r, addr_nxt;
  logic           rtag_vld_r, rtag_vld_nxt;
  logic [1:0]     rtag_ph_r, rtag_ph_nxt;
  logic [7:0]     b_r, b_nxt;
  logic [7:0]     data_r, data_nxt;
  count_t         mod_rem_r, mod_rem_nxt;
  wide_t          mod_dvd_r, mod_dvd_nxt;
  logic [MOD_CW-1:0] mod_cnt_r, mod_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;

  // Digit store: single port, registered read
  logic [3:0]     mem [DIGIT_DEPTH];
  logic [3:0]     rd_data_r;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;

  logic           in_acc;
  logic           load_ok;
  count_t         n_eff;
  logic [LW-1:0]  k_last;
  logic [LW-1:0]  lay_idx;
  wide_t          lay_sum;
  count_t         lay_addr;
  wide_t          inc_sum;
  count_t         inc_addr;
  wide_t          rem_sh;
  count_t         rem_step;
  logic           mod_done;
  logic [RW-1:0]  red_idx;
  wide_t          red_dvd;
  logic [10:0]    wprod;
  logic [7:0]     plain;
  logic [7:0]     step;
  wide_t          adv_sum;
  wide_t          adv_sub;

  assign in_ready  = (state_r == ST_IDLE) && !dirty_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign in_acc    = in_valid && in_ready;

  // Effective digit count: zero counts as one, clamp to the store
  always_comb begin
    if (count_r == '0) begin
      n_eff = count_t'(1);
    end else if (count_r > count_t'(CAP)) begin
      n_eff = count_t'(CAP);
    end else begin
      n_eff = count_r;
    end
  end

  // Index of the last active layer
  always_comb begin
    if (layers_r == '0) begin
      k_last = '0;
    end else if (layers_r > 3'(LIM)) begin
      k_last = LW'(LIM - 1);
    end else begin
      k_last = LW'(layers_r - 3'd1);
    end
  end

  // First digit of a layer: position plus reduced offset, folded once
  assign lay_idx  = (state_r == ST_IDLE) ? '0 : LW'(j_r + 1'b1);
  assign lay_sum  = {1'b0, pos_r} + {1'b0, off_red_r[lay_idx]};
  assign lay_addr = (lay_sum >= {1'b0, n_eff}) ? count_t'(lay_sum - {1'b0, n_eff})
                                               : count_t'(lay_sum);

  // Following digit, wrapping at the count
  assign inc_sum  = {1'b0, addr_r} + wide_t'(1);
  assign inc_addr = (inc_sum >= {1'b0, n_eff}) ? '0 : count_t'(inc_sum);

  // Remainder unit step
  assign rem_sh   = {mod_rem_r, mod_dvd_r[CNT_W]};
  assign rem_step = (rem_sh >= {1'b0, n_eff}) ? count_t'(rem_sh - {1'b0, n_eff})
                                              : count_t'(rem_sh);
  assign mod_done = (mod_cnt_r == MOD_CW'(1));

  // Next value to reduce: offsets first, position last
  assign red_idx = (state_r == ST_IDLE) ? '0 : RW'(ridx_r + 1'b1);
  assign red_dvd = (red_idx == RW'(LIM)) ? {1'b0, pos_r}
                                         : {2'b00, offset_r[OFS_IW'(red_idx)]};

  // Weighted digit, only its low byte matters
  always_comb begin
    case (rtag_ph_r)
      PH_HUND: wprod = 11'(rd_data_r) * W_HUND;
      PH_TENS: wprod = 11'(rd_data_r) * W_TENS;
      default: wprod = 11'(rd_data_r);
    endcase
  end

  // Position advance by the plaintext byte
  assign plain   = direction_r ? b_r : data_r;
  assign step    = (plain == 8'd0) ? 8'd1 : plain;
  assign adv_sum = {1'b0, pos_r} + wide_t'(step);
  assign adv_sub = adv_sum - {1'b0, n_eff};

  assign load_ok  = 32'(in_digit_address) < DIGIT_DEPTH;
  assign mem_we   = in_acc && (in_command == CMD_LOAD) && load_ok;
  assign mem_addr = (state_r == ST_IDLE) ? AW'(in_digit_address) : AW'(addr_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_digit_value;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    dirty_nxt     = dirty_r;
    direction_nxt = direction_r;
    layers_nxt    = layers_r;
    count_nxt     = count_r;
    offset_nxt    = offset_r;
    off_red_nxt   = off_red_r;
    pos_nxt       = pos_r;
    ridx_nxt      = ridx_r;
    j_nxt         = j_r;
    ph_nxt        = ph_r;
    addr_nxt      = addr_r;
    rtag_vld_nxt  = 1'b0;
    rtag_ph_nxt   = ph_r;
    b_nxt         = b_r;
    data_nxt      = data_r;
    mod_rem_nxt   = mod_rem_r;
    mod_dvd_nxt   = mod_dvd_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;

    // Remainder unit runs on its own once started
    if (mod_cnt_r != '0) begin
      mod_rem_nxt = rem_step;
      mod_dvd_nxt = mod_dvd_r << 1;
      mod_cnt_nxt = mod_cnt_r - 1'b1;
    end

    // Returned digit folds into the byte
    if (rtag_vld_r) begin
      b_nxt = direction_r ? (b_r - wprod[7:0]) : (b_r + wprod[7:0]);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          mod_rem_nxt = '0;
          mod_dvd_nxt = red_dvd;
          mod_cnt_nxt = MOD_CW'(MOD_STEPS);
          ridx_nxt    = '0;
          state_nxt   = ST_RED;
        end else if (in_acc) begin
          case (in_command)
            CMD_START: begin
              pos_nxt = off_red_r[0];
            end
            CMD_PROCESS: begin
              data_nxt = in_data_byte;
              b_nxt    = in_data_byte;
              if (in_bypass) begin
                state_nxt = ST_DONE;
              end else begin
                j_nxt     = '0;
                ph_nxt    = PH_HUND;
                addr_nxt  = lay_addr;
                state_nxt = ST_LAYER;
              end
            end
            default: ;  // load goes straight to the store; drop unknown codes
          endcase
        end
      end
      ST_RED: begin
        if (mod_done) begin
          if (ridx_r == RW'(LIM)) begin
            pos_nxt   = rem_step;
            dirty_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            off_red_nxt[LW'(ridx_r)] = rem_step;
            ridx_nxt    = red_idx;
            mod_rem_nxt = '0;
            mod_dvd_nxt = red_dvd;
            mod_cnt_nxt = MOD_CW'(MOD_STEPS);
          end
        end
      end
      ST_LAYER: begin
        rtag_vld_nxt = 1'b1;
        if (ph_r == PH_ONES) begin
          if (j_r == k_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            j_nxt    = LW'(j_r + 1'b1);
            ph_nxt   = PH_HUND;
            addr_nxt = lay_addr;
          end
        end else begin
          ph_nxt   = ph_r + 2'd1;
          addr_nxt = inc_addr;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (adv_sum < {1'b0, n_eff}) begin
          pos_nxt   = count_t'(adv_sum);
          state_nxt = ST_DONE;
        end else if (adv_sub < {1'b0, n_eff}) begin
          pos_nxt   = count_t'(adv_sub);
          state_nxt = ST_DONE;
        end else begin
          mod_rem_nxt = '0;
          mod_dvd_nxt = adv_sum;
          mod_cnt_nxt = MOD_CW'(MOD_STEPS);
          state_nxt   = ST_MODP;
        end
      end
      ST_MODP: begin
        if (mod_done) begin
          pos_nxt   = rem_step;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold here while the output register is still full
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = b_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; any write restarts the reduction pass
    if (cfg_valid && cfg_ready) begin
      dirty_nxt = 1'b1;
      if (state_r == ST_RED) begin
        state_nxt   = ST_IDLE;
        mod_cnt_nxt = '0;
      end
      case (cfg_index)
        CFG_DIRECTION: direction_nxt = cfg_data[0];
        CFG_LAYERS:    layers_nxt    = cfg_data[2:0];
        CFG_COUNT:     count_nxt     = count_t'(cfg_data);
        CFG_OFFSET_0:  offset_nxt[0] = cfg_data[15:0];
        CFG_OFFSET_1:  offset_nxt[1] = cfg_data[15:0];
        CFG_OFFSET_2:  offset_nxt[2] = cfg_data[15:0];
        CFG_OFFSET_3:  offset_nxt[3] = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= 1'b0;
      direction_r <= 1'b0;
      layers_r    <= LAYERS_RESET;
      count_r     <= COUNT_RESET;
      offset_r    <= '{default: '0};
      off_red_r   <= '{default: '0};
      pos_r       <= '0;
      ridx_r      <= '0;
      rtag_vld_r  <= 1'b0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      direction_r <= direction_nxt;
      layers_r    <= layers_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      off_red_r   <= off_red_nxt;
      pos_r       <= pos_nxt;
      ridx_r      <= ridx_nxt;
      rtag_vld_r  <= rtag_vld_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    ph_r       <= ph_nxt;
    addr_r     <= addr_nxt;
    rtag_ph_r  <= rtag_ph_nxt;
    b_r        <= b_nxt;
    data_r     <= data_nxt;
    mod_rem_r  <= mod_rem_nxt;
    mod_dvd_r  <= mod_dvd_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // Position must stay folded whenever a beat can be taken
  `ASSERT_IMPL(a_pos_folded, (state_r == ST_IDLE) && !dirty_r, {1'b0, pos_r} < {1'b0, n_eff}, "position not below digit count")
  // Digit reads return only while a byte is being worked
  `ASSERT_IMPL(a_rtag_in_layer, rtag_vld_r, (state_r == ST_LAYER) || (state_r == ST_DRAIN), "digit returned outside layer walk")
  // Remainder unit busy only in its own states
  `ASSERT_IMPL(a_mod_owner, mod_cnt_r != '0, (state_r == ST_RED) || (state_r == ST_MODP), "remainder unit running unowned")
  // One byte at a time
  `ASSERT_NEXT(a_one_byte, in_valid && in_ready && (in_command == CMD_PROCESS), !in_ready, "beat taken while a byte is in work")

endmodule
